// ===== sv/sart_pkg.sv =====
package sart_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_BITS   = 64;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        t_addr rng_start;
        t_addr rng_end;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ACT_MATCHED = 2'd0,
        ACT_ADDED   = 2'd1,
        ACT_UPDATED = 2'd2,
        ACT_FULL    = 2'd3
    } t_action;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PROBE  = 1'b1;

    typedef struct packed {
        logic   rd_en;
        t_idx   rd_addr;
        logic   wr_en;
        t_idx   wr_addr;
        t_entry wr_data;
    } t_ram_req;

endpackage

// ===== sv/sart_ram.sv =====
module sart_ram
    import sart_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]                         i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]                         o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sorted_address_range_table_core.sv =====
// Sorted address range table. Holds up to TABLE_DEPTH half-open ranges
// [start, end) in one entry RAM, kept in ascending order of start. An update
// (op 0) either inserts a new start in order, rewrites the end of an existing
// start, or leaves the table alone; a new start on a full table is refused
// with action 3. A probe (op 1) reports whether the address falls in any
// range. Every result carries the lowest start, highest end, empty flag and
// a gap flag (sum of lengths vs. span, modulo 2^ADDR_BITS). Items are
// handled one at a time. Each pass over the table reads the stored entries
// one by one through the single RAM read port, and each entry is consumed
// the cycle after. An update makes up to three passes (search, shift on
// insert, summary pass); a probe makes only the summary pass. A finished
// result sits in the output register, so the next transaction can be
// accepted while it waits.
module sorted_address_range_table_core
    import sart_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [63:0] i_range_start,
    input  logic [63:0] i_range_end,
    input  logic [63:0] i_probe_addr,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic        o_covered,
    output logic [63:0] o_span_low,
    output logic [63:0] o_span_high,
    output logic        o_gaps_present,
    output logic        o_table_empty
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INS,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_FIN
    } t_state;

    t_state   r_state;
    t_cnt     r_count;
    t_cnt     r_idx;
    t_cnt     r_pos;
    logic     r_hit;
    t_addr    r_hit_end;
    logic     r_op;
    t_addr    r_s;
    t_addr    r_e;
    t_addr    r_a;
    t_action  r_act;
    logic     r_cov;
    t_addr    r_lo;
    t_addr    r_hi;
    t_addr    r_len;

    logic     r_out_valid;
    t_action  r_out_action;
    logic     r_out_covered;
    t_addr    r_out_lo;
    t_addr    r_out_hi;
    logic     r_out_gaps;
    logic     r_out_empty;

    t_ram_req ram_req;
    t_entry   rd_entry;
    logic     upd_end;
    logic     in_xact;

    assign in_xact = i_in_valid && o_in_ready;
    assign upd_end = r_hit && (r_hit_end != r_e);

    sart_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_entry)
    );

    always_comb begin
        ram_req         = '0;
        ram_req.rd_addr = r_idx[IDX_W-1:0];
        case (r_state)
            ST_SRCH_RD: ram_req.rd_en = (r_idx != r_count);
            ST_SUM_RD:  ram_req.rd_en = (r_idx != r_count);
            ST_SHIFT_RD: begin
                ram_req.rd_en   = (r_idx != r_pos);
                ram_req.rd_addr = t_idx'(r_idx - t_cnt'(1));
            end
            ST_DECIDE: begin
                ram_req.wr_en   = upd_end;
                ram_req.wr_addr = r_pos[IDX_W-1:0];
                ram_req.wr_data = '{rng_start: r_s, rng_end: r_e};
            end
            ST_SHIFT_WR: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_idx[IDX_W-1:0];
                ram_req.wr_data = rd_entry;
            end
            ST_INS: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_pos[IDX_W-1:0];
                ram_req.wr_data = '{rng_start: r_s, rng_end: r_e};
            end
            default: ram_req.rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in ST_FIN the output register is reloaded below instead
            if (r_out_valid && i_out_ready && r_state != ST_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xact) begin
                        r_op  <= i_op;
                        r_s   <= i_range_start[ADDR_BITS-1:0];
                        r_e   <= i_range_end[ADDR_BITS-1:0];
                        r_a   <= i_probe_addr[ADDR_BITS-1:0];
                        r_act <= ACT_MATCHED;
                        r_cov <= 1'b0;
                        r_hit <= 1'b0;
                        r_idx <= '0;
                        r_lo  <= '1;
                        r_hi  <= '0;
                        r_len <= '0;
                        r_state <= (i_op == OP_PROBE) ? ST_SUM_RD : ST_SRCH_RD;
                    end
                end
                ST_SRCH_RD: begin
                    if (r_idx == r_count) begin
                        r_pos   <= r_count;
                        r_state <= ST_DECIDE;
                    end else begin
                        r_state <= ST_SRCH_CMP;
                    end
                end
                ST_SRCH_CMP: begin
                    if (rd_entry.rng_start == r_s) begin
                        r_hit     <= 1'b1;
                        r_hit_end <= rd_entry.rng_end;
                        r_pos     <= r_idx;
                        r_state   <= ST_DECIDE;
                    end else if (rd_entry.rng_start > r_s) begin
                        r_pos   <= r_idx;
                        r_state <= ST_DECIDE;
                    end else begin
                        r_idx   <= r_idx + t_cnt'(1);
                        r_state <= ST_SRCH_RD;
                    end
                end
                ST_DECIDE: begin
                    if (r_hit) begin
                        r_act   <= upd_end ? ACT_UPDATED : ACT_MATCHED;
                        r_idx   <= '0;
                        r_state <= ST_SUM_RD;
                    end else if (r_count == t_cnt'(TABLE_DEPTH)) begin
                        r_act   <= ACT_FULL;
                        r_idx   <= '0;
                        r_state <= ST_SUM_RD;
                    end else begin
                        // open a hole at r_pos by moving the tail up one slot
                        r_idx   <= r_count;
                        r_state <= ST_SHIFT_RD;
                    end
                end
                ST_SHIFT_RD: begin
                    r_state <= (r_idx == r_pos) ? ST_INS : ST_SHIFT_WR;
                end
                ST_SHIFT_WR: begin
                    r_idx   <= r_idx - t_cnt'(1);
                    r_state <= ST_SHIFT_RD;
                end
                ST_INS: begin
                    r_act   <= ACT_ADDED;
                    r_count <= r_count + t_cnt'(1);
                    r_idx   <= '0;
                    r_state <= ST_SUM_RD;
                end
                ST_SUM_RD: begin
                    r_state <= (r_idx == r_count) ? ST_FIN : ST_SUM_ACC;
                end
                ST_SUM_ACC: begin
                    if (rd_entry.rng_start < r_lo) begin
                        r_lo <= rd_entry.rng_start;
                    end
                    if (rd_entry.rng_end > r_hi) begin
                        r_hi <= rd_entry.rng_end;
                    end
                    r_len <= r_len + rd_entry.rng_end - rd_entry.rng_start;
                    if (r_op == OP_PROBE && r_a >= rd_entry.rng_start
                            && r_a < rd_entry.rng_end) begin
                        r_cov <= 1'b1;
                    end
                    r_idx   <= r_idx + t_cnt'(1);
                    r_state <= ST_SUM_RD;
                end
                ST_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_action  <= r_act;
                        r_out_covered <= r_cov;
                        r_out_lo      <= r_lo;
                        r_out_hi      <= r_hi;
                        r_out_gaps    <= (r_count != '0) && (r_len != (r_hi - r_lo));
                        r_out_empty   <= (r_count == '0);
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_action       = r_out_action;
    assign o_covered      = r_out_covered;
    assign o_span_low     = 64'(r_out_lo);
    assign o_span_high    = 64'(r_out_hi);
    assign o_gaps_present = r_out_gaps;
    assign o_table_empty  = r_out_empty;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_FULL) |-> (r_count == t_cnt'(TABLE_DEPTH)))
        else $error("table full reported with free entries");

    a_empty_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_empty) |-> (o_span_high == '0 && !o_gaps_present))
        else $error("empty table with nonzero summary");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_req.wr_en)
        else $error("entry RAM written while idle");
`endif

endmodule
